// ----- src/sffa_pkg.sv -----
`timescale 1ns / 1ps
// constants and types shared by the allocator engine and its adder unit
// no dependencies

package sffa_pkg;

  localparam int FREE_ENTRIES_DEF = 16;
  localparam int ADDR_BITS_DEF    = 16;

  // general heap and the three dedicated blocks
  localparam int HEAP_BASE  = 60;
  localparam int HEAP_RESET = 120;
  localparam int DED0_SIZE  = 10;
  localparam int DED0_ADDR  = 0;
  localparam int DED1_SIZE  = 20;
  localparam int DED1_ADDR  = 10;
  localparam int DED2_SIZE  = 30;
  localparam int DED2_ADDR  = 30;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2,
    ST_ZERO  = 2'd3
  } status_t;

endpackage

// ----- src/sffa_alu.sv -----
`timescale 1ns / 1ps
// shared add / subtract unit with an equality compare on the sum
// depends on sffa_pkg for the default address width

module sffa_alu
  import sffa_pkg::*;
#(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic [ADDR_BITS-1:0] a,
  input  logic [ADDR_BITS-1:0] b,
  input  logic [ADDR_BITS-1:0] c,
  input  logic                 sub,
  output logic [ADDR_BITS:0]   res,
  output logic                 eq
);

  logic [ADDR_BITS:0] b_x;

  // on subtract the top bit of res is the borrow (a < b)
  assign b_x = {1'b0, b} ^ {(ADDR_BITS + 1){sub}};
  assign res = {1'b0, a} + b_x + {{ADDR_BITS{1'b0}}, sub};
  assign eq  = (res == {1'b0, c});

endmodule

// ----- src/segregated_first_fit_allocator_unit.sv -----
`timescale 1ns / 1ps
// allocator request engine: dedicated blocks plus a first-fit ordered extent table
// depends on sffa_pkg and sffa_alu
//
//   channel | signals                                       | dir
//   --------+-----------------------------------------------+-----
//   in      | in_valid/in_ready, req_type, req_size, req_address | in
//   out     | out_valid/out_ready, status, block_address, block_size | out
//   cfg     | cfg_valid/cfg_ready, cfg_data (heap_size)      | in
//
// zero-size and dedicated requests go from idle straight to S_FIN. an allocate walks the extent
// table one entry a cycle through the single memory read port. a heap free reads the same way
// and then uses the shared adder in S_MP1, S_MP2 and S_MN before S_ACT picks the action.
// removing or inserting an entry moves the entries after it one at a time (S_SHDN, S_SHUP),
// and an insert then writes the new entry in S_INS.
// after reset the S_INIT state writes the initial extent; in_ready is low during it.
// a finished result waits in the output register; the next request is taken only
// once the result has moved there.

module segregated_first_fit_allocator_unit
  import sffa_pkg::*;
#(
  parameter int FREE_ENTRIES = FREE_ENTRIES_DEF,
  parameter int ADDR_BITS    = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [15:0] in_req_size,
  input  logic [15:0] in_req_address,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_block_address,
  output logic [15:0] out_block_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int IW = $clog2(FREE_ENTRIES);
  localparam int CW = $clog2(FREE_ENTRIES + 1);
  localparam int XW = (ADDR_BITS > 16) ? ADDR_BITS : 16;
  localparam int VW = (ADDR_BITS >= 16) ? ADDR_BITS + 1 : 17;
  localparam logic [ADDR_BITS:0] ROOM =
    (ADDR_BITS + 1)'((64'd1 << ADDR_BITS) - 64'(HEAP_BASE));
  localparam logic [ADDR_BITS-1:0] AMASK = {ADDR_BITS{1'b1}};

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] len;
  } ent_t;

  typedef enum logic [11:0] {
    S_INIT = 12'b0000_0000_0001,
    S_IDLE = 12'b0000_0000_0010,
    S_SCAN = 12'b0000_0000_0100,
    S_AUPD = 12'b0000_0000_1000,
    S_MP1  = 12'b0000_0001_0000,
    S_MP2  = 12'b0000_0010_0000,
    S_MN   = 12'b0000_0100_0000,
    S_ACT  = 12'b0000_1000_0000,
    S_SHDN = 12'b0001_0000_0000,
    S_SHUP = 12'b0010_0000_0000,
    S_INS  = 12'b0100_0000_0000,
    S_FIN  = 12'b1000_0000_0000
  } state_t;

  ent_t mem [FREE_ENTRIES];
  ent_t mem_q;

  state_t               state_r, state_nxt;
  logic [CW-1:0]        count_r, count_nxt;
  logic [CW-1:0]        p_r, p_nxt;
  logic [CW-1:0]        pos_r, pos_nxt;
  logic [CW-1:0]        raddr_r;
  logic                 dv_r;
  logic [2:0]           ded_r, ded_nxt;
  ent_t                 prev_r, prev_nxt;
  ent_t                 next_r, next_nxt;
  logic [ADDR_BITS-1:0] size_r, size_nxt;
  logic [ADDR_BITS-1:0] addr_r, addr_nxt;
  logic [ADDR_BITS-1:0] end_r, end_nxt;
  logic [ADDR_BITS-1:0] merged_r, merged_nxt;
  logic [ADDR_BITS-1:0] sum_r, sum_nxt;
  logic                 pe_r, pe_nxt;
  logic                 mp_r, mp_nxt;
  logic                 mn_r, mn_nxt;
  logic                 is_free_r, is_free_nxt;
  status_t              st_r, st_nxt;
  logic [ADDR_BITS-1:0] baddr_r, baddr_nxt;
  logic [ADDR_BITS-1:0] bsize_r, bsize_nxt;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r, out_status_nxt;
  logic [15:0]          out_addr_r, out_addr_nxt;
  logic [15:0]          out_size_r, out_size_nxt;

  logic                 re, we;
  logic [CW-1:0]        ra, wa_c;
  ent_t                 wd;

  logic [ADDR_BITS-1:0] alu_a, alu_b, alu_c;
  logic                 alu_sub;
  logic [ADDR_BITS:0]   alu_res;
  logic                 alu_eq;

  logic [XW-1:0]        size_x, addr_x, baddr_x, bsize_x;
  logic [ADDR_BITS-1:0] size_m, addr_m;
  logic [2:0]           hit_alloc, hit_free;
  logic [VW-1:0]        clamp_x, room_x, len_x;
  logic [ADDR_BITS-1:0] heap_len;
  logic [CW-1:0]        pos_m1, pos_p1, raddr_m1, raddr_p1, p_m1, p_p1;
  logic                 cfg_fire;

  sffa_alu #(
    .ADDR_BITS(ADDR_BITS)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .c   (alu_c),
    .sub (alu_sub),
    .res (alu_res),
    .eq  (alu_eq)
  );

  assign size_x = XW'(in_req_size);
  assign addr_x = XW'(in_req_address);
  assign size_m = size_x[ADDR_BITS-1:0];
  assign addr_m = addr_x[ADDR_BITS-1:0];

  assign hit_alloc[0] = (size_m == ADDR_BITS'(DED0_SIZE));
  assign hit_alloc[1] = (size_m == ADDR_BITS'(DED1_SIZE));
  assign hit_alloc[2] = (size_m == ADDR_BITS'(DED2_SIZE));
  assign hit_free[0]  = hit_alloc[0] && (addr_m == ADDR_BITS'(DED0_ADDR));
  assign hit_free[1]  = hit_alloc[1] && (addr_m == ADDR_BITS'(DED1_ADDR));
  assign hit_free[2]  = hit_alloc[2] && (addr_m == ADDR_BITS'(DED2_ADDR));

  // heap length clamp, shared by the reset fill and register writes
  assign cfg_fire = cfg_valid && cfg_ready;
  assign clamp_x  = cfg_fire ? VW'(cfg_data) : VW'(HEAP_RESET);
  assign room_x   = VW'(ROOM);
  assign len_x    = (clamp_x > room_x) ? room_x : clamp_x;
  assign heap_len = len_x[ADDR_BITS-1:0];

  assign pos_m1   = pos_r - CW'(1);
  assign pos_p1   = pos_r + CW'(1);
  assign raddr_m1 = raddr_r - CW'(1);
  assign raddr_p1 = raddr_r + CW'(1);
  assign p_m1     = p_r - CW'(1);
  assign p_p1     = p_r + CW'(1);

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    p_nxt          = p_r;
    pos_nxt        = pos_r;
    ded_nxt        = ded_r;
    prev_nxt       = prev_r;
    next_nxt       = next_r;
    size_nxt       = size_r;
    addr_nxt       = addr_r;
    end_nxt        = end_r;
    merged_nxt     = merged_r;
    sum_nxt        = sum_r;
    pe_nxt         = pe_r;
    mp_nxt         = mp_r;
    mn_nxt         = mn_r;
    is_free_nxt    = is_free_r;
    st_nxt         = st_r;
    baddr_nxt      = baddr_r;
    bsize_nxt      = bsize_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_size_nxt   = out_size_r;
    re             = 1'b0;
    ra             = '0;
    we             = 1'b0;
    wa_c           = '0;
    wd             = '0;
    alu_a          = '0;
    alu_b          = '0;
    alu_c          = '0;
    alu_sub        = 1'b0;
    baddr_x        = '0;
    bsize_x        = '0;

    case (state_r)
      S_INIT: begin
        we        = 1'b1;
        wd        = '{start: ADDR_BITS'(HEAP_BASE), len: heap_len};
        state_nxt = S_IDLE;
      end

      S_IDLE: begin
        // end of the freed range, used for truncation
        alu_a = addr_m;
        alu_b = size_m;
        if (in_valid) begin
          size_nxt    = size_m;
          addr_nxt    = addr_m;
          is_free_nxt = in_req_type;
          baddr_nxt   = '0;
          bsize_nxt   = size_m;
          st_nxt      = ST_OK;
          p_nxt       = '0;
          if (size_m == '0) begin
            st_nxt    = ST_ZERO;
            state_nxt = S_FIN;
          end else if (!in_req_type) begin
            if ((hit_alloc & ded_r) != 3'b000) begin
              ded_nxt   = ded_r & ~hit_alloc;
              baddr_nxt = hit_alloc[0] ? ADDR_BITS'(DED0_ADDR) :
                          hit_alloc[1] ? ADDR_BITS'(DED1_ADDR) : ADDR_BITS'(DED2_ADDR);
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_SCAN;
            end
          end else if (hit_free != 3'b000) begin
            ded_nxt   = ded_r | hit_free;
            baddr_nxt = addr_m;
            state_nxt = S_FIN;
          end else begin
            // a range running past the top is cut to end at the top
            size_nxt  = alu_res[ADDR_BITS] ? ~addr_m : size_m;
            bsize_nxt = alu_res[ADDR_BITS] ? ~addr_m : size_m;
            end_nxt   = alu_res[ADDR_BITS] ? AMASK : alu_res[ADDR_BITS-1:0];
            if (alu_res[ADDR_BITS] && (~addr_m == '0)) begin
              st_nxt    = ST_ZERO;
              state_nxt = S_FIN;
            end else begin
              state_nxt = S_SCAN;
            end
          end
        end
      end

      S_SCAN: begin
        if (p_r < count_r) begin
          re    = 1'b1;
          ra    = p_r;
          p_nxt = p_p1;
        end
        alu_sub = 1'b1;
        if (!is_free_r) begin
          alu_a = mem_q.len;
          alu_b = size_r;
        end else begin
          alu_a = addr_r;
          alu_b = mem_q.start;
        end
        if (dv_r) begin
          if (!is_free_r) begin
            if (!alu_res[ADDR_BITS]) begin
              prev_nxt   = mem_q;
              pos_nxt    = raddr_r;
              merged_nxt = alu_res[ADDR_BITS-1:0];
              re         = 1'b0;
              state_nxt  = S_AUPD;
            end
          end else if (alu_res[ADDR_BITS]) begin
            // first extent starting above the freed address
            next_nxt  = mem_q;
            pos_nxt   = raddr_r;
            re        = 1'b0;
            state_nxt = S_MP1;
          end else begin
            prev_nxt = mem_q;
          end
        end else if (p_r >= count_r) begin
          if (!is_free_r) begin
            st_nxt    = ST_NOFIT;
            state_nxt = S_FIN;
          end else begin
            pos_nxt   = count_r;
            state_nxt = S_MP1;
          end
        end
      end

      S_AUPD: begin
        alu_a     = prev_r.start;
        alu_b     = size_r;
        baddr_nxt = prev_r.start;
        if (merged_r == '0) begin
          p_nxt     = pos_p1;
          state_nxt = S_SHDN;
        end else begin
          we        = 1'b1;
          wa_c      = pos_r;
          wd        = '{start: alu_res[ADDR_BITS-1:0], len: merged_r};
          state_nxt = S_FIN;
        end
      end

      S_MP1: begin
        alu_a     = prev_r.start;
        alu_b     = prev_r.len;
        alu_c     = addr_r;
        pe_nxt    = alu_eq && (pos_r != '0);
        state_nxt = S_MP2;
      end

      S_MP2: begin
        alu_a      = prev_r.len;
        alu_b      = size_r;
        mp_nxt     = pe_r && !alu_res[ADDR_BITS];
        merged_nxt = (pe_r && !alu_res[ADDR_BITS]) ? alu_res[ADDR_BITS-1:0] : size_r;
        state_nxt  = S_MN;
      end

      S_MN: begin
        alu_a     = merged_r;
        alu_b     = next_r.len;
        mn_nxt    = (pos_r < count_r) && (end_r == next_r.start) && !alu_res[ADDR_BITS];
        sum_nxt   = alu_res[ADDR_BITS-1:0];
        state_nxt = S_ACT;
      end

      S_ACT: begin
        if (mp_r && mn_r) begin
          we        = 1'b1;
          wa_c      = pos_m1;
          wd        = '{start: prev_r.start, len: sum_r};
          baddr_nxt = addr_r;
          p_nxt     = pos_p1;
          state_nxt = S_SHDN;
        end else if (mp_r) begin
          we        = 1'b1;
          wa_c      = pos_m1;
          wd        = '{start: prev_r.start, len: merged_r};
          baddr_nxt = addr_r;
          state_nxt = S_FIN;
        end else if (mn_r) begin
          we        = 1'b1;
          wa_c      = pos_r;
          wd        = '{start: addr_r, len: sum_r};
          baddr_nxt = addr_r;
          state_nxt = S_FIN;
        end else if (count_r >= CW'(FREE_ENTRIES)) begin
          st_nxt    = ST_FULL;
          state_nxt = S_FIN;
        end else begin
          baddr_nxt = addr_r;
          p_nxt     = count_r;
          state_nxt = S_SHUP;
        end
      end

      S_SHDN: begin
        // close the gap: entry k+1 moves to k
        if (p_r < count_r) begin
          re    = 1'b1;
          ra    = p_r;
          p_nxt = p_p1;
        end
        if (dv_r) begin
          we   = 1'b1;
          wa_c = raddr_m1;
          wd   = mem_q;
        end else if (p_r >= count_r) begin
          count_nxt = count_r - CW'(1);
          state_nxt = S_FIN;
        end
      end

      S_SHUP: begin
        // open a slot at pos, moving from the top down
        if (p_r > pos_r) begin
          re    = 1'b1;
          ra    = p_m1;
          p_nxt = p_m1;
        end
        if (dv_r) begin
          we   = 1'b1;
          wa_c = raddr_p1;
          wd   = mem_q;
        end else if (p_r <= pos_r) begin
          state_nxt = S_INS;
        end
      end

      S_INS: begin
        we        = 1'b1;
        wa_c      = pos_r;
        wd        = '{start: addr_r, len: size_r};
        count_nxt = count_r + CW'(1);
        state_nxt = S_FIN;
      end

      S_FIN: begin
        baddr_x = XW'(baddr_r);
        bsize_x = XW'(bsize_r);
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = st_r;
          out_addr_nxt   = baddr_x[15:0];
          out_size_nxt   = bsize_x[15:0];
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // register write rebuilds the table as one extent, or as an empty table when the clamped length is zero
    if (cfg_fire) begin
      we        = 1'b1;
      wa_c      = '0;
      wd        = '{start: ADDR_BITS'(HEAP_BASE), len: heap_len};
      count_nxt = (heap_len == '0) ? CW'(0) : CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa_c[IW-1:0]] <= wd;
    end
    if (re) begin
      mem_q <= mem[ra[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      count_r     <= CW'(1);
      p_r         <= '0;
      dv_r        <= 1'b0;
      ded_r       <= 3'b111;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      p_r         <= p_nxt;
      dv_r        <= re;
      ded_r       <= ded_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    raddr_r      <= ra;
    pos_r        <= pos_nxt;
    prev_r       <= prev_nxt;
    next_r       <= next_nxt;
    size_r       <= size_nxt;
    addr_r       <= addr_nxt;
    end_r        <= end_nxt;
    merged_r     <= merged_nxt;
    sum_r        <= sum_nxt;
    pe_r         <= pe_nxt;
    mp_r         <= mp_nxt;
    mn_r         <= mn_nxt;
    is_free_r    <= is_free_nxt;
    st_r         <= st_nxt;
    baddr_r      <= baddr_nxt;
    bsize_r      <= bsize_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_size_r   <= out_size_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;
  assign out_block_size    = out_size_r;

endmodule
